// ----- design/rvde_pkg.sv -----
// Shared constants, pipeline payload type and datapath functions of the RV32IM execute block.
package rvde_pkg;

    localparam logic [6:0] OPC_LOAD    = 7'd3;
    localparam logic [6:0] OPC_OPIMM   = 7'd19;
    localparam logic [6:0] OPC_OPIMM32 = 7'd27;
    localparam logic [6:0] OPC_JALR    = 7'd103;
    localparam logic [6:0] OPC_AUIPC   = 7'd23;
    localparam logic [6:0] OPC_LUI     = 7'd55;
    localparam logic [6:0] OPC_STORE   = 7'd35;
    localparam logic [6:0] OPC_OP      = 7'd51;
    localparam logic [6:0] OPC_OP32    = 7'd59;
    localparam logic [6:0] OPC_BRANCH  = 7'd99;
    localparam logic [6:0] OPC_JAL     = 7'd111;

    localparam logic [6:0] F7_BASE = 7'd0;
    localparam logic [6:0] F7_MULDIV = 7'd1;
    localparam logic [6:0] F7_ALT  = 7'd32;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;

    // result source codes
    localparam logic [2:0] SEL_BASE = 3'd0;
    localparam logic [2:0] SEL_MUL  = 3'd1;
    localparam logic [2:0] SEL_MULH = 3'd2;
    localparam logic [2:0] SEL_DIV  = 3'd3;
    localparam logic [2:0] SEL_REM  = 3'd4;

    localparam int XLEN       = 32;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STG    = XLEN / DIV_BITS;
    localparam int NSTG       = DIV_STG + 2;

    typedef struct packed {
        logic [4:0]         rd_index;
        logic               rd_write;
        logic               from_mem;
        logic [31:0]        next_pc;
        logic [1:0]         lsz;
        logic [1:0]         ssz;
        logic [31:0]        sdata;
        logic [31:0]        res;
        logic [2:0]         sel;
        logic               neg_q;
        logic               neg_r;
        logic               div_zero;
        logic [31:0]        dvd_a;
        logic signed [49:0] mul_p0;
        logic signed [49:0] mul_p1;
        logic [31:0]        dv_rem;
        logic [31:0]        dv_quo;
        logic [31:0]        dv_div;
    } t_pipe;

    function automatic logic [31:0] f_alu(logic [2:0] f3, logic alt,
                                          logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        case (f3)
            F3_ADD:  r = alt ? a - b : a + b;
            F3_SLL:  r = a << b[4:0];
            F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: r = {31'd0, a < b};
            F3_XOR:  r = a ^ b;
            F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   r = a | b;
            default: r = a & b;
        endcase
        return r;
    endfunction

    // restoring division, DIV_BITS quotient bits per call
    function automatic t_pipe f_div_step(t_pipe p);
        t_pipe       q;
        logic [32:0] t;
        logic [32:0] d;
        q = p;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {q.dv_rem, q.dv_quo[31]};
            d = t - {1'b0, q.dv_div};
            if (!d[32]) begin
                q.dv_rem = d[31:0];
            end else begin
                q.dv_rem = t[31:0];
            end
            q.dv_quo = {q.dv_quo[30:0], ~d[32]};
        end
        return q;
    endfunction

    function automatic t_pipe f_final(t_pipe p);
        t_pipe q;
        q = p;
        case (p.sel)
            SEL_DIV: q.res = p.div_zero ? 32'hFFFF_FFFF : (p.neg_q ? -p.dv_quo : p.dv_quo);
            SEL_REM: q.res = p.div_zero ? p.dvd_a : (p.neg_r ? -p.dv_rem : p.dv_rem);
            default: q.res = p.res;
        endcase
        q.sel = SEL_BASE;
        return q;
    endfunction

endpackage

// ----- design/rvde_ifs.sv -----
// Valid/ready channel interfaces for instruction beats and result beats.
interface rvde_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        instruction;
    logic [31:0]        pc;
    logic signed [31:0] rs1_value;
    logic signed [31:0] rs2_value;
    modport source (output valid, instruction, pc, rs1_value, rs2_value, input ready);
    modport sink   (input valid, instruction, pc, rs1_value, rs2_value, output ready);
endinterface

interface rvde_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         rd_index;
    logic               rd_write;
    logic signed [31:0] result;
    logic               result_from_memory;
    logic [31:0]        next_pc;
    logic [1:0]         load_size;
    logic [1:0]         store_size;
    logic signed [31:0] store_data;
    modport source (output valid, rd_index, rd_write, result, result_from_memory, next_pc,
                    load_size, store_size, store_data, input ready);
    modport sink   (input valid, rd_index, rd_write, result, result_from_memory, next_pc,
                    load_size, store_size, store_data, output ready);
endinterface

// ----- design/rv32im_decode_execute.sv -----
// RV32IM decode and execute unit, fully pipelined.
// Channels: i_item takes one instruction beat (word, pc, rs1 and rs2 values);
// o_result gives one result beat per instruction (rd, write enable, result,
// load flag and size, store size and data, next pc), in order.
// Throughput: one instruction per cycle while the receiver is not stalling.
// The first stage decodes and runs the ALU, branch unit and two 17x33
// partial multipliers; sixteen stages then each resolve two quotient bits of
// the restoring divider, the first of them also summing the product; the
// last stage fixes quotient and remainder signs and is the output register.
// Reset clears all stage valid bits; the pipeline then accepts at once.
// When the receiver stalls with a result waiting, every stage holds and
// i_item.ready falls in the same cycle; nothing is dropped or repeated.
module rv32im_decode_execute
    import rvde_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    rvde_in_if.sink     i_item,
    rvde_out_if.source  o_result
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    t_pipe           r_p [NSTG];
    t_pipe           n_p [NSTG];
    logic            w_adv;
    logic            w_acc;

    logic [31:0] w_ins, w_pc, w_a, w_b, w_seq;
    logic [6:0]  w_opc, w_f7;
    logic [4:0]  w_rd;
    logic [2:0]  w_f3;
    logic [31:0] w_imm_i, w_imm_s, w_imm_b, w_imm_j;
    logic        w_sgn_a, w_sgn_b, w_neg_a, w_neg_b, w_sdiv;
    logic signed [32:0] w_pa, w_pb;
    logic signed [49:0] w_p0, w_p1;
    logic [65:0] w_full;
    t_pipe       w_d;
    logic        w_ok, w_wr, w_cond;

    assign w_adv = !r_vld[NSTG-1] || o_result.ready;
    assign w_acc = i_item.valid && w_adv;
    assign i_item.ready = w_adv;

    assign w_ins = i_item.instruction;
    assign w_pc  = i_item.pc;
    assign w_a   = i_item.rs1_value;
    assign w_b   = i_item.rs2_value;
    assign w_seq = w_pc + 32'd4;
    assign w_opc = w_ins[6:0];
    assign w_rd  = w_ins[11:7];
    assign w_f3  = w_ins[14:12];
    assign w_f7  = w_ins[31:25];
    assign w_imm_i = {{20{w_ins[31]}}, w_ins[31:20]};
    assign w_imm_s = {{20{w_ins[31]}}, w_ins[31:25], w_ins[11:7]};
    assign w_imm_b = {{19{w_ins[31]}}, w_ins[31], w_ins[7], w_ins[30:25], w_ins[11:8], 1'b0};
    assign w_imm_j = {{11{w_ins[31]}}, w_ins[31], w_ins[19:12], w_ins[20], w_ins[30:21], 1'b0};

    // multiplier operands, 33-bit signed to cover mulh / mulhsu / mulhu
    assign w_sgn_a = (w_f3 == F3_SLL) || (w_f3 == F3_SLT);
    assign w_sgn_b = (w_f3 == F3_SLL);
    assign w_pa = $signed({w_sgn_a & w_a[31], w_a});
    assign w_pb = $signed({w_sgn_b & w_b[31], w_b});
    assign w_p0 = 50'($signed({1'b0, w_pa[15:0]}) * w_pb);
    assign w_p1 = 50'($signed(w_pa[32:16]) * w_pb);

    // divider operand signs: div and rem are even funct3 codes
    assign w_sdiv  = !w_f3[0];
    assign w_neg_a = w_sdiv && w_a[31];
    assign w_neg_b = w_sdiv && w_b[31];

    always_comb begin
        w_d    = '0;
        w_ok   = 1'b0;
        w_wr   = 1'b0;
        w_cond = 1'b0;
        w_d.next_pc = w_seq;
        case (w_opc)
            OPC_LOAD: begin
                if (w_f3 <= F3_SLT) begin
                    w_ok = 1'b1;
                    w_wr = 1'b1;
                    w_d.from_mem = 1'b1;
                    w_d.lsz = w_f3[1:0] + 2'd1;
                    w_d.res = w_a + w_imm_i;
                end
            end
            OPC_STORE: begin
                if (w_f3 <= F3_SLT) begin
                    w_ok = 1'b1;
                    w_d.ssz = w_f3[1:0] + 2'd1;
                    w_d.res = w_a + w_imm_s;
                    w_d.sdata = w_b;
                end
            end
            OPC_OPIMM, OPC_OPIMM32: begin
                if (w_f3 == F3_SLL || w_f3 == F3_SR) begin
                    if (w_f7 == F7_BASE || (w_f3 == F3_SR && w_f7 == F7_ALT)) begin
                        w_ok = 1'b1;
                        w_wr = 1'b1;
                        w_d.res = f_alu(w_f3, w_f7 == F7_ALT, w_a, {27'd0, w_ins[24:20]});
                    end
                end else if (w_opc == OPC_OPIMM || w_f3 == F3_ADD) begin
                    w_ok = 1'b1;
                    w_wr = 1'b1;
                    w_d.res = f_alu(w_f3, 1'b0, w_a, w_imm_i);
                end
            end
            OPC_OP, OPC_OP32: begin
                if (w_f7 == F7_MULDIV) begin
                    if (w_opc == OPC_OP || w_f3 == F3_ADD || w_f3[2]) begin
                        w_ok = 1'b1;
                        w_wr = 1'b1;
                        case (w_f3)
                            F3_ADD:               w_d.sel = SEL_MUL;
                            F3_SLL, F3_SLT, F3_SLTU: w_d.sel = SEL_MULH;
                            F3_XOR, F3_SR:        w_d.sel = SEL_DIV;
                            default:              w_d.sel = SEL_REM;
                        endcase
                    end
                end else if (w_f7 == F7_BASE ||
                             (w_f7 == F7_ALT && (w_f3 == F3_ADD || w_f3 == F3_SR))) begin
                    if (w_opc == OPC_OP || w_f3 == F3_ADD || w_f3 == F3_SLL || w_f3 == F3_SR)
                    begin
                        w_ok = 1'b1;
                        w_wr = 1'b1;
                        w_d.res = f_alu(w_f3, w_f7 == F7_ALT, w_a, w_b);
                    end
                end
            end
            OPC_AUIPC: begin
                w_ok = 1'b1;
                w_wr = 1'b1;
                w_d.res = w_pc + {w_ins[31:12], 12'd0};
            end
            OPC_LUI: begin
                w_ok = 1'b1;
                w_wr = 1'b1;
                w_d.res = {w_ins[31:12], 12'd0};
            end
            OPC_JAL: begin
                w_ok = 1'b1;
                w_wr = 1'b1;
                w_d.res = w_seq;
                w_d.next_pc = w_pc + w_imm_j;
            end
            OPC_JALR: begin
                if (w_f3 == F3_ADD) begin
                    w_ok = 1'b1;
                    w_wr = 1'b1;
                    w_d.res = w_seq;
                    w_d.next_pc = (w_a + w_imm_i) & ~32'd1;
                end
            end
            OPC_BRANCH: begin
                if (w_f3 != F3_SLT && w_f3 != F3_SLTU) begin
                    w_ok = 1'b1;
                    case (w_f3)
                        F3_BEQ:  w_cond = (w_a == w_b);
                        F3_BNE:  w_cond = (w_a != w_b);
                        F3_BLT:  w_cond = ($signed(w_a) < $signed(w_b));
                        F3_BGE:  w_cond = !($signed(w_a) < $signed(w_b));
                        F3_BLTU: w_cond = (w_a < w_b);
                        default: w_cond = (w_a >= w_b);
                    endcase
                    if (w_cond) begin
                        w_d.next_pc = w_pc + w_imm_b;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!w_ok) begin
            w_d = '0;
            w_d.next_pc = w_seq;
        end
        w_d.rd_index = w_wr ? w_rd : 5'd0;
        w_d.rd_write = w_wr && (w_rd != 5'd0);
        w_d.mul_p0   = w_p0;
        w_d.mul_p1   = w_p1;
        w_d.neg_q    = w_neg_a ^ w_neg_b;
        w_d.neg_r    = w_neg_a;
        w_d.div_zero = (w_b == 32'd0);
        w_d.dvd_a    = w_a;
        w_d.dv_rem   = '0;
        w_d.dv_quo   = w_neg_a ? -w_a : w_a;
        w_d.dv_div   = w_neg_b ? -w_b : w_b;
    end

    assign w_full = {{16{r_p[0].mul_p0[49]}}, r_p[0].mul_p0} + {r_p[0].mul_p1, 16'd0};

    always_comb begin
        n_vld = {r_vld[NSTG-2:0], w_acc};
        n_p[0] = w_d;
        for (int k = 1; k < NSTG - 1; k++) begin
            n_p[k] = f_div_step(r_p[k-1]);
        end
        if (r_p[0].sel == SEL_MUL) begin
            n_p[1].res = w_full[31:0];
            n_p[1].sel = SEL_BASE;
        end else if (r_p[0].sel == SEL_MULH) begin
            n_p[1].res = w_full[63:32];
            n_p[1].sel = SEL_BASE;
        end
        n_p[NSTG-1] = f_final(r_p[NSTG-2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
        if (w_adv) begin
            r_p <= n_p;
        end
    end

    assign o_result.valid              = r_vld[NSTG-1];
    assign o_result.rd_index           = r_p[NSTG-1].rd_index;
    assign o_result.rd_write           = r_p[NSTG-1].rd_write;
    assign o_result.result             = r_p[NSTG-1].res;
    assign o_result.result_from_memory = r_p[NSTG-1].from_mem;
    assign o_result.next_pc            = r_p[NSTG-1].next_pc;
    assign o_result.load_size          = r_p[NSTG-1].lsz;
    assign o_result.store_size         = r_p[NSTG-1].ssz;
    assign o_result.store_data         = r_p[NSTG-1].sdata;

`ifndef ASSERT_OFF
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_vld[0])
        else $error("accepted beat not captured");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld) && $stable(r_p[NSTG-1]))
        else $error("pipeline moved during stall");
    a_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && r_p[NSTG-1].rd_write |-> r_p[NSTG-1].rd_index != 5'd0)
        else $error("write to x0 enabled");
    a_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] |-> (r_p[NSTG-1].from_mem == (r_p[NSTG-1].lsz != 2'd0))
                          && !(r_p[NSTG-1].ssz != 2'd0 && r_p[NSTG-1].rd_write))
        else $error("load/store flags inconsistent");
`endif

endmodule

// ----- bench/tb_rv32im_decode_execute.sv -----
// Testbench for the RV32IM decode and execute unit: random and directed beats, scoreboard check.
`timescale 1ns / 100ps
module tb_rv32im_decode_execute;
    import rvde_pkg::*;

    typedef struct {
        logic [31:0] instruction;
        logic [31:0] pc;
        logic [31:0] rs1_value;
        logic [31:0] rs2_value;
    } t_instr;

    typedef struct {
        logic [4:0]  rd_index;
        logic        rd_write;
        logic [31:0] result;
        logic        result_from_memory;
        logic [31:0] next_pc;
        logic [1:0]  load_size;
        logic [1:0]  store_size;
        logic [31:0] store_data;
    } t_outcome;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    rvde_in_if  in_ch ();
    rvde_out_if out_ch ();

    rv32im_decode_execute dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch.sink),
        .o_result (out_ch.source)
    );

    t_instr   pending_q[$];
    t_outcome outcome_q[$];
    int       n_errors;
    int       cycle_cnt;
    bit       hold_rx;
    bit       pause_tx;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic signed [31:0] sx(logic [31:0] v, int bits);
        logic [31:0] m;
        m = (32'd1 << bits) - 32'd1;
        v = v & m;
        if (v[bits-1]) begin
            v = v | ~m;
        end
        return v;
    endfunction

    function automatic logic [31:0] alu_calc(logic [2:0] f3, logic alt,
                                             logic [31:0] a, logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << sh;
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> sh) : a >> sh;
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic [31:0] muldiv_calc(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0]        p;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        case (f3)
            F3_MUL:    return a * b;
            F3_MULH:   begin p = sa * sb; return p[63:32]; end
            F3_MULHSU: begin p = sa * $signed({32'd0, b}); return p[63:32]; end
            F3_MULHU:  begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
            F3_DIV: begin
                if (b == 0) return 32'hFFFF_FFFF;
                p = sa / sb;
                return p[31:0];
            end
            F3_DIVU: return (b == 0) ? 32'hFFFF_FFFF : a / b;
            F3_REM: begin
                if (b == 0) return a;
                p = sa % sb;
                return p[31:0];
            end
            default: return (b == 0) ? a : a % b;
        endcase
    endfunction

    function automatic t_outcome execute_instr(t_instr it);
        t_outcome    o;
        logic [6:0]  opc;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] ins;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_j;
        logic [31:0] res;
        logic [31:0] target;
        logic [31:0] sdata;
        logic [1:0]  lsz;
        logic [1:0]  ssz;
        logic        ok;
        logic        wr;
        logic        mem;
        logic        taken;
        logic        c;
        ins = it.instruction;
        a = it.rs1_value;
        b = it.rs2_value;
        opc = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        f7 = ins[31:25];
        imm_i = sx(ins[31:20], 12);
        imm_s = sx({ins[31:25], ins[11:7]}, 12);
        imm_b = sx({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
        imm_j = sx({ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
        ok = 0; wr = 0; mem = 0; taken = 0; c = 0;
        res = 0; target = 0; sdata = 0; lsz = 0; ssz = 0;
        case (opc)
            OPC_LOAD: if (f3 <= F3_LW) begin
                ok = 1; wr = 1; mem = 1; lsz = f3[1:0] + 2'd1; res = a + imm_i;
            end
            OPC_STORE: if (f3 <= F3_LW) begin
                ok = 1; ssz = f3[1:0] + 2'd1; res = a + imm_s; sdata = b;
            end
            OPC_OPIMM, OPC_OPIMM32: begin
                if (f3 == F3_SLL || f3 == F3_SR) begin
                    if (f7 == F7_BASE || (f3 == F3_SR && f7 == F7_ALT)) begin
                        ok = 1; wr = 1;
                        res = alu_calc(f3, f7 == F7_ALT, a, {27'd0, ins[24:20]});
                    end
                end else if (opc == OPC_OPIMM || f3 == F3_ADD) begin
                    ok = 1; wr = 1; res = alu_calc(f3, 1'b0, a, imm_i);
                end
            end
            OPC_OP, OPC_OP32: begin
                if (f7 == F7_MULDIV) begin
                    if (opc == OPC_OP || f3 == F3_MUL || f3 >= F3_DIV) begin
                        ok = 1; wr = 1; res = muldiv_calc(f3, a, b);
                    end
                end else if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)))
                begin
                    if (opc == OPC_OP || f3 == F3_ADD || f3 == F3_SLL || f3 == F3_SR) begin
                        ok = 1; wr = 1; res = alu_calc(f3, f7 == F7_ALT, a, b);
                    end
                end
            end
            OPC_AUIPC: begin ok = 1; wr = 1; res = it.pc + {ins[31:12], 12'd0}; end
            OPC_LUI:   begin ok = 1; wr = 1; res = {ins[31:12], 12'd0}; end
            OPC_JAL: begin
                ok = 1; wr = 1; taken = 1; res = it.pc + 4; target = it.pc + imm_j;
            end
            OPC_JALR: if (f3 == F3_ADD) begin
                ok = 1; wr = 1; taken = 1; res = it.pc + 4;
                target = (a + imm_i) & ~32'd1;
            end
            OPC_BRANCH: if (f3 != F3_SLT && f3 != F3_SLTU) begin
                ok = 1;
                case (f3)
                    F3_BEQ:  c = (a == b);
                    F3_BNE:  c = (a != b);
                    F3_BLT:  c = $signed(a) < $signed(b);
                    F3_BGE:  c = !($signed(a) < $signed(b));
                    F3_BLTU: c = a < b;
                    default: c = a >= b;
                endcase
                if (c) begin
                    taken = 1; target = it.pc + imm_b;
                end
            end
            default: ;
        endcase
        if (!ok) begin
            wr = 0; mem = 0; taken = 0; res = 0; lsz = 0; ssz = 0; sdata = 0;
        end
        o.rd_index = wr ? rd : 5'd0;
        o.rd_write = wr && rd != 0;
        o.result = res;
        o.result_from_memory = mem;
        o.next_pc = taken ? target : it.pc + 4;
        o.load_size = lsz;
        o.store_size = ssz;
        o.store_data = sdata;
        return o;
    endfunction

    // driver: bursts and gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                outcome_q.push_back(execute_instr('{in_ch.instruction, in_ch.pc,
                                                   in_ch.rs1_value, in_ch.rs2_value}));
            end
            if (gap_left > 0 || pause_tx || pending_q.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                t_instr it;
                it = pending_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.instruction <= it.instruction;
                in_ch.pc <= it.pc;
                in_ch.rs1_value <= it.rs1_value;
                in_ch.rs2_value <= it.rs2_value;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern
    int rx_phase;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_phase <= 0;
        end else begin
            rx_phase <= rx_phase + 1;
            if (hold_rx) out_ch.ready <= 1'b0;
            else if (rx_phase[10]) out_ch.ready <= 1'b1;
            else if (rx_phase[8]) out_ch.ready <= ($urandom_range(7, 0) != 0);
            else out_ch.ready <= ($urandom_range(2, 0) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (outcome_q.size() == 0) begin
                $error("result beat with nothing expected");
                n_errors++;
            end else begin
                t_outcome e;
                e = outcome_q.pop_front();
                if (out_ch.rd_index !== e.rd_index) begin
                    $error("rd_index exp %0d got %0d", e.rd_index, out_ch.rd_index);
                    n_errors++;
                end
                if (out_ch.rd_write !== e.rd_write) begin
                    $error("rd_write exp %0d got %0d", e.rd_write, out_ch.rd_write);
                    n_errors++;
                end
                if (out_ch.result !== e.result) begin
                    $error("result exp %h got %h", e.result, out_ch.result);
                    n_errors++;
                end
                if (out_ch.result_from_memory !== e.result_from_memory) begin
                    $error("result_from_memory exp %0d got %0d", e.result_from_memory,
                           out_ch.result_from_memory);
                    n_errors++;
                end
                if (out_ch.next_pc !== e.next_pc) begin
                    $error("next_pc exp %h got %h", e.next_pc, out_ch.next_pc);
                    n_errors++;
                end
                if (out_ch.load_size !== e.load_size) begin
                    $error("load_size exp %0d got %0d", e.load_size, out_ch.load_size);
                    n_errors++;
                end
                if (out_ch.store_size !== e.store_size) begin
                    $error("store_size exp %0d got %0d", e.store_size, out_ch.store_size);
                    n_errors++;
                end
                if (out_ch.store_data !== e.store_data) begin
                    $error("store_data exp %h got %h", e.store_data, out_ch.store_data);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** rv32im_decode_execute: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7, 0))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(8, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        logic [6:0]  opcs[11];
        logic [31:0] w;
        logic [6:0]  f7;
        opcs = '{OPC_LOAD, OPC_OPIMM, OPC_OPIMM32, OPC_JALR, OPC_AUIPC, OPC_LUI,
                 OPC_STORE, OPC_OP, OPC_OP32, OPC_BRANCH, OPC_JAL};
        w = $urandom;
        if ($urandom_range(9, 0) == 0) return w;
        w[6:0] = opcs[$urandom_range(10, 0)];
        if (w[6:0] == OPC_OP || w[6:0] == OPC_OP32 ||
            ((w[6:0] == OPC_OPIMM || w[6:0] == OPC_OPIMM32) && w[13:12] == 2'b01)) begin
            case ($urandom_range(4, 0))
                0, 1: f7 = F7_BASE;
                2:    f7 = F7_MULDIV;
                3:    f7 = F7_ALT;
                default: f7 = 7'($urandom);
            endcase
            w[31:25] = f7;
        end
        return w;
    endfunction

    task automatic add_instr(logic [31:0] ins, logic [31:0] a, logic [31:0] b);
        pending_q.push_back('{ins, $urandom, a, b});
    endtask

    // with pause_tx set, waits only for the beats already sent
    task automatic wait_drained();
        @(posedge i_clk);
        while ((pending_q.size() != 0 && !pause_tx) || in_ch.valid || outcome_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        n_errors = 0;
        cycle_cnt = 0;
        hold_rx = 0;
        pause_tx = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.instruction = '0;
        in_ch.pc = '0;
        in_ch.rs1_value = '0;
        in_ch.rs2_value = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and special cases
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OPC_OP}, 32'h8000_0000, 32'hFFFF_FFFF);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd3, OPC_OP}, 32'h8000_0000, 32'hFFFF_FFFF);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OPC_OP}, 32'h1234, 32'h0);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_DIVU, 5'd3, OPC_OP}, 32'h1234, 32'h0);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd3, OPC_OP}, 32'h8765_4321, 32'h0);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_REMU, 5'd3, OPC_OP}, 32'hFFFF_FFFF, 32'h0);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd3, OPC_OP}, 32'h8000_0000, 32'h8000_0000);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_MULHSU, 5'd3, OPC_OP}, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        add_instr({F7_MULDIV, 5'd2, 5'd1, F3_MULHU, 5'd3, OPC_OP}, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        add_instr({F7_ALT, 5'd31, 5'd1, F3_SR, 5'd4, OPC_OPIMM}, 32'h8000_0000, 0);
        add_instr({12'hFFF, 5'd1, F3_SLT, 5'd5, OPC_OPIMM}, 32'h0, 0);
        add_instr({12'hFFF, 5'd1, F3_SLTU, 5'd5, OPC_OPIMM}, 32'h0, 0);
        add_instr({12'h001, 5'd1, F3_ADD, 5'd6, OPC_JALR}, 32'h1000, 0);
        add_instr({12'h0, 5'd1, F3_LW, 5'd0, OPC_LOAD}, 32'hFFFF_FFFC, 0);
        add_instr({12'h7FF, 5'd1, F3_LD, 5'd7, OPC_LOAD}, 32'h10, 0);
        add_instr({7'h7F, 5'd2, 5'd1, F3_SB, 5'h1F, OPC_STORE}, 32'h0, 32'hDEAD_BEEF);
        add_instr({1'b1, 6'h3F, 5'd2, 5'd1, F3_BLT, 4'hF, 1'b1, OPC_BRANCH},
                  32'h8000_0000, 32'h7FFF_FFFF);
        add_instr({1'b1, 6'h3F, 5'd2, 5'd1, F3_BLTU, 4'hF, 1'b1, OPC_BRANCH},
                  32'h8000_0000, 32'h7FFF_FFFF);
        add_instr({1'b0, 6'h00, 5'd2, 5'd1, F3_SLT, 4'h2, 1'b0, OPC_BRANCH}, 0, 0);
        add_instr({20'hFFFFF, 5'd1, OPC_JAL}, 0, 0);
        add_instr({20'h80000, 5'd9, OPC_AUIPC}, 0, 0);
        add_instr({20'hFFFFF, 5'd9, OPC_LUI}, 0, 0);
        add_instr({F7_ALT, 5'd2, 5'd1, F3_SR, 5'd3, OPC_OP32}, 32'h8000_0000, 32'd4);
        add_instr({F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd3, OPC_OP32}, 1, 2);
        add_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int i = 0; i < 1725; i++) begin
            while (pending_q.size() > 64) @(posedge i_clk);
            add_instr(random_word(), pick_operand(), pick_operand());
            if (i == 600) begin
                hold_rx = 1;
                for (int j = 0; j < 100; j++) add_instr(random_word(), pick_operand(),
                                                        pick_operand());
                repeat (300) @(posedge i_clk);
                hold_rx = 0;
            end
            if (i == 1200) begin
                pause_tx = 1;
                wait_drained();
                pause_tx = 0;
            end
        end
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && outcome_q.size() == 0) begin
            $display("** rv32im_decode_execute: PASSED **");
        end else begin
            $display("** rv32im_decode_execute: FAILED **");
        end
        $finish;
    end
endmodule

// ----- rv32im_decode_execute.f -----
design/rvde_pkg.sv
design/rvde_ifs.sv
design/rv32im_decode_execute.sv
bench/tb_rv32im_decode_execute.sv
